[rtl/tksk_pkg.sv]
`timescale 1ns / 1ps

package tksk_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DUMP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam int unsigned ScoreW = 6;
  localparam int unsigned SigW   = 32;
  localparam int unsigned IdW    = 16;
  localparam int unsigned RankW  = 6;
  localparam int unsigned FillW  = 7;
  localparam int unsigned KeepW  = 7;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ScoreW-1:0] new_score;
    logic [SigW-1:0]   new_signature;
    logic [IdW-1:0]    new_id;
  } in_t;

  typedef struct packed {
    logic              entry_valid;
    logic              accepted;
    logic [RankW-1:0]  rank;
    logic [ScoreW-1:0] entry_score;
    logic [SigW-1:0]   entry_signature;
    logic [IdW-1:0]    entry_id;
    logic [FillW-1:0]  fill_level;
    logic              is_last;
  } out_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [SigW-1:0]   signature;
    logic [IdW-1:0]    id;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHK     = 7'b0000010,
    S_START   = 7'b0000100,
    S_SHIFT   = 7'b0001000,
    S_DUMP_RD = 7'b0010000,
    S_DUMP_WR = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_e;

endpackage

[rtl/tksk_mem.sv]
`timescale 1ns / 1ps

module tksk_mem import tksk_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tksk_ctrl.sv]
`timescale 1ns / 1ps

module tksk_ctrl import tksk_pkg::*; #(
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CW-1:0] keep_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_t           in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_t          out_data_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output entry_t        wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  entry_t        rdata_i
);

  state_e        state_q, state_d;
  in_t           cur_q, cur_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] newcnt_q, newcnt_d;
  logic [CW-1:0] held_q, held_d;
  out_t          res_q, res_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          slot_free;
  logic [CW-1:0] held_eff;
  entry_t        new_entry;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign held_eff  = (held_q > keep_i) ? keep_i : held_q;
  assign new_entry = '{score: cur_q.new_score, signature: cur_q.new_signature,
                       id: cur_q.new_id};

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    newcnt_d    = newcnt_q;
    held_d      = held_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we_o        = 1'b0;
    waddr_o     = idx_q;
    wdata_o     = new_entry;
    re_o        = 1'b0;
    raddr_o     = idx_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d = in_data_i;
          res_d = '0;
          res_d.is_last = 1'b1;
          case (in_data_i.req_type)
            REQ_INSERT: begin
              held_d = held_eff;
              if (held_eff < keep_i) begin
                idx_d    = AW'(held_eff);
                newcnt_d = held_eff + CW'(1);
                state_d  = S_START;
              end else begin
                re_o    = 1'b1;
                raddr_o = AW'(keep_i - CW'(1));
                state_d = S_CHK;
              end
            end
            REQ_DUMP: begin
              if (held_q == '0) begin
                state_d = S_EMIT;
              end else begin
                idx_d   = '0;
                state_d = S_DUMP_RD;
              end
            end
            REQ_CLEAR: begin
              held_d  = '0;
              state_d = S_EMIT;
            end
            default: begin
              res_d.fill_level = FillW'(held_q);
              state_d          = S_EMIT;
            end
          endcase
        end
      end
      S_CHK: begin
        if (cur_q.new_score > rdata_i.score) begin
          idx_d    = AW'(keep_i - CW'(1));
          newcnt_d = keep_i;
          state_d  = S_START;
        end else begin
          res_d.fill_level = FillW'(held_q);
          state_d          = S_EMIT;
        end
      end
      S_START: begin
        if (idx_q == '0) begin
          we_o             = 1'b1;
          held_d           = newcnt_q;
          res_d.accepted   = 1'b1;
          res_d.rank       = '0;
          res_d.fill_level = FillW'(newcnt_q);
          state_d          = S_EMIT;
        end else begin
          re_o    = 1'b1;
          raddr_o = idx_q - AW'(1);
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we_o = 1'b1;
        if (rdata_i.score >= cur_q.new_score) begin
          held_d           = newcnt_q;
          res_d.accepted   = 1'b1;
          res_d.rank       = RankW'(idx_q);
          res_d.fill_level = FillW'(newcnt_q);
          state_d          = S_EMIT;
        end else begin
          wdata_o = rdata_i;
          idx_d   = idx_q - AW'(1);
          if (idx_q == AW'(1)) begin
            state_d = S_START;
          end else begin
            re_o    = 1'b1;
            raddr_o = idx_q - AW'(2);
          end
        end
      end
      S_DUMP_RD: begin
        re_o    = 1'b1;
        state_d = S_DUMP_WR;
      end
      S_DUMP_WR: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_d                 = '0;
          out_d.entry_valid     = 1'b1;
          out_d.rank            = RankW'(idx_q);
          out_d.entry_score     = rdata_i.score;
          out_d.entry_signature = rdata_i.signature;
          out_d.entry_id        = rdata_i.id;
          out_d.fill_level      = FillW'(held_q);
          out_d.is_last         = (CW'(idx_q) + CW'(1) == held_q);
          if (CW'(idx_q) + CW'(1) == held_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_DUMP_RD;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    newcnt_q <= newcnt_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule

[rtl/top_k_score_keeper.sv]
`timescale 1ns / 1ps

// channel  direction  handshake       payload
// in       input      valid / stall   in_t  (req_type, new_score, new_signature, new_id)
// out      output     valid / stall   out_t (one beat per result, is_last on the final)
// cfg      input      valid / ready   keep_size, 7 bits
//
// one request at a time; an insert moves one entry per cycle through the single read / single
// write entry memory until its slot is found; a reject or a clear needs no shifting
// a dump reads each entry in S_DUMP_RD and emits it in S_DUMP_WR, holding while the output stalls
// reset clears the count and sets keep_size to 64; entry memory is not cleared, no sweep needed
// a stalled output holds the result register; the input stalls until the request is done

module top_k_score_keeper import tksk_pkg::*; #(
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [KeepW-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned CW = $clog2(MAX_KEEP + 1);

  logic [KeepW-1:0] keep_q;
  logic [KeepW-1:0] keep_lim;
  logic [CW-1:0]    keep_eff;

  logic             we;
  logic [AW-1:0]    waddr;
  entry_t           wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  entry_t           rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KeepW'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      keep_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (keep_q == '0) begin
      keep_lim = KeepW'(1);
    end else if (keep_q > KeepW'(MAX_KEEP)) begin
      keep_lim = KeepW'(MAX_KEEP);
    end else begin
      keep_lim = keep_q;
    end
  end

  assign keep_eff = CW'(keep_lim);

  tksk_ctrl #(
    .AW (AW),
    .CW (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .keep_i      (keep_eff),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  tksk_mem #(
    .Depth (MAX_KEEP),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
